FILE: rtl/core/assert_macros.svh
// assertion macros used by quaternion_vector_rotator
// each macro expands to one labeled concurrent assertion on clock, qualified by reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QVR_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QVR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/qvr_pkg.sv
// types, constants and step tables for the quaternion vector rotator
// used by qvr_ctrl, qvr_datapath and quaternion_vector_rotator
package qvr_pkg;

   localparam int PROD_W = 64;   // full 32x32 product
   localparam int TERM_W = 35;   // product after the q30 or q29 shift
   localparam int ACC_W  = 36;   // sum of up to four terms
   localparam int WIDE_W = 38;   // headroom for matrix entries and sign scaling
   localparam int STEP_W = 4;

   localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

   localparam logic [STEP_W-1:0] COMPOSE_LAST = 4'd15;
   localparam logic [STEP_W-1:0] SQUARE_LAST  = 4'd8;
   localparam logic [STEP_W-1:0] ROTATE_LAST  = 4'd8;

   // products of quaternion components kept for the matrix build
   localparam logic [3:0] SQ_XX = 4'd0;
   localparam logic [3:0] SQ_YY = 4'd1;
   localparam logic [3:0] SQ_ZZ = 4'd2;
   localparam logic [3:0] SQ_XY = 4'd3;
   localparam logic [3:0] SQ_XZ = 4'd4;
   localparam logic [3:0] SQ_YZ = 4'd5;
   localparam logic [3:0] SQ_XW = 4'd6;
   localparam logic [3:0] SQ_YW = 4'd7;
   localparam logic [3:0] SQ_ZW = 4'd8;

   // quaternion component indexes
   localparam logic [1:0] QI_X = 2'd0;
   localparam logic [1:0] QI_Y = 2'd1;
   localparam logic [1:0] QI_Z = 2'd2;
   localparam logic [1:0] QI_W = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COMPOSE,
      ST_QDRAIN,
      ST_SQUARE,
      ST_SDRAIN,
      ST_MATRIX,
      ST_ROTATE,
      ST_RDRAIN,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      PH_COMPOSE,
      PH_SQUARE,
      PH_ROTATE
   } phase_type;

   typedef struct packed {
      logic              capture;
      logic              issue;
      phase_type         phase;
      logic [STEP_W-1:0] step;
      logic              build;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] a_idx;
      logic [1:0] b_idx;
      logic       neg;
   } comp_op_type;

   typedef struct packed {
      logic [1:0] a_idx;
      logic [1:0] b_idx;
   } sq_op_type;

   // hamilton product q * p, four terms per component, x y z w order
   function automatic comp_op_type compose_op(input logic [STEP_W-1:0] step);
      comp_op_type op;
      unique case (step)
         4'd0:    op = '{QI_Y, QI_Z, 1'b0};
         4'd1:    op = '{QI_Z, QI_Y, 1'b1};
         4'd2:    op = '{QI_X, QI_W, 1'b0};
         4'd3:    op = '{QI_W, QI_X, 1'b0};
         4'd4:    op = '{QI_Z, QI_X, 1'b0};
         4'd5:    op = '{QI_X, QI_Z, 1'b1};
         4'd6:    op = '{QI_Y, QI_W, 1'b0};
         4'd7:    op = '{QI_W, QI_Y, 1'b0};
         4'd8:    op = '{QI_X, QI_Y, 1'b0};
         4'd9:    op = '{QI_Y, QI_X, 1'b1};
         4'd10:   op = '{QI_Z, QI_W, 1'b0};
         4'd11:   op = '{QI_W, QI_Z, 1'b0};
         4'd12:   op = '{QI_W, QI_W, 1'b0};
         4'd13:   op = '{QI_X, QI_X, 1'b1};
         4'd14:   op = '{QI_Y, QI_Y, 1'b1};
         4'd15:   op = '{QI_Z, QI_Z, 1'b1};
         default: op = '{QI_X, QI_X, 1'b0};
      endcase
      return op;
   endfunction

   // component pairs in SQ_* order
   function automatic sq_op_type square_op(input logic [STEP_W-1:0] step);
      sq_op_type op;
      unique case (step)
         SQ_XX:   op = '{QI_X, QI_X};
         SQ_YY:   op = '{QI_Y, QI_Y};
         SQ_ZZ:   op = '{QI_Z, QI_Z};
         SQ_XY:   op = '{QI_X, QI_Y};
         SQ_XZ:   op = '{QI_X, QI_Z};
         SQ_YZ:   op = '{QI_Y, QI_Z};
         SQ_XW:   op = '{QI_X, QI_W};
         SQ_YW:   op = '{QI_Y, QI_W};
         SQ_ZW:   op = '{QI_Z, QI_W};
         default: op = '{QI_X, QI_X};
      endcase
      return op;
   endfunction

   // matrix walk is row major: column is step mod 3
   function automatic logic [1:0] rot_col(input logic [STEP_W-1:0] step);
      logic [1:0] col;
      unique case (step)
         4'd0, 4'd3, 4'd6: col = 2'd0;
         4'd1, 4'd4, 4'd7: col = 2'd1;
         4'd2, 4'd5, 4'd8: col = 2'd2;
         default:          col = 2'd0;
      endcase
      return col;
   endfunction

   function automatic logic [1:0] rot_row(input logic [STEP_W-1:0] step);
      logic [1:0] row;
      unique case (step)
         4'd0, 4'd1, 4'd2: row = 2'd0;
         4'd3, 4'd4, 4'd5: row = 2'd1;
         4'd6, 4'd7, 4'd8: row = 2'd2;
         default:          row = 2'd0;
      endcase
      return row;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-32:0] top;
      logic signed [31:0] r;
      top = v[WIDE_W-1:31];
      if (&top || ~|top) begin
         r = v[31:0];
      end else begin
         r = {v[WIDE_W-1], {31{~v[WIDE_W-1]}}};
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/qvr_ctrl.sv
// sequencer for the quaternion vector rotator: walks compose, square, matrix
// and rotate steps and owns both handshakes; uses qvr_pkg
module qvr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_op,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qvr_pkg::cmd_type  cmd
);

   qvr_pkg::state_type           state_ff, state_in;
   logic [qvr_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_free;
   logic                         accept;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && (state_ff == qvr_pkg::ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qvr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = req_op ? qvr_pkg::ST_COMPOSE : qvr_pkg::ST_ROTATE;
            end
         end
         qvr_pkg::ST_COMPOSE: begin
            if (step_ff == qvr_pkg::COMPOSE_LAST) state_in = qvr_pkg::ST_QDRAIN;
         end
         qvr_pkg::ST_QDRAIN: state_in = qvr_pkg::ST_SQUARE;
         qvr_pkg::ST_SQUARE: begin
            if (step_ff == qvr_pkg::SQUARE_LAST) state_in = qvr_pkg::ST_SDRAIN;
         end
         qvr_pkg::ST_SDRAIN: state_in = qvr_pkg::ST_MATRIX;
         qvr_pkg::ST_MATRIX: state_in = qvr_pkg::ST_ROTATE;
         qvr_pkg::ST_ROTATE: begin
            if (step_ff == qvr_pkg::ROTATE_LAST) state_in = qvr_pkg::ST_RDRAIN;
         end
         qvr_pkg::ST_RDRAIN: state_in = qvr_pkg::ST_RESULT;
         qvr_pkg::ST_RESULT: begin
            if (out_free) state_in = qvr_pkg::ST_IDLE;
         end
         default: state_in = qvr_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.capture  = accept;
      cmd.issue    = state_ff inside {qvr_pkg::ST_COMPOSE, qvr_pkg::ST_SQUARE,
                                      qvr_pkg::ST_ROTATE};
      cmd.step     = step_ff;
      cmd.build    = (state_ff == qvr_pkg::ST_MATRIX);
      cmd.out_load = (state_ff == qvr_pkg::ST_RESULT) && out_free;
      unique case (state_ff)
         qvr_pkg::ST_COMPOSE: cmd.phase = qvr_pkg::PH_COMPOSE;
         qvr_pkg::ST_SQUARE:  cmd.phase = qvr_pkg::PH_SQUARE;
         default:             cmd.phase = qvr_pkg::PH_ROTATE;
      endcase
      req_stall    = (state_ff != qvr_pkg::ST_IDLE);
      rsp_valid    = rsp_valid_ff;
      // step restarts whenever the state changes
      step_in      = (cmd.issue && state_in == state_ff) ? step_ff + 4'd1 : '0;
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qvr_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/qvr_datapath.sv
// datapath of the quaternion vector rotator: one shared 32x32 multiplier,
// term accumulator, quaternion and matrix state, output register; uses qvr_pkg
module qvr_datapath #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  qvr_pkg::cmd_type    cmd,
   input  logic signed [31:0]  req_vec_x,
   input  logic signed [31:0]  req_vec_y,
   input  logic signed [31:0]  req_vec_z,
   input  logic signed [1:0]   req_sign_mult,
   input  logic signed [31:0]  req_quat_x,
   input  logic signed [31:0]  req_quat_y,
   input  logic signed [31:0]  req_quat_z,
   input  logic signed [31:0]  req_quat_w,
   output logic signed [31:0]  rsp_out_x,
   output logic signed [31:0]  rsp_out_y,
   output logic signed [31:0]  rsp_out_z
);

   localparam int OUT_W = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
   localparam int PW = qvr_pkg::PROD_W;
   localparam int TW = qvr_pkg::TERM_W;
   localparam int AW = qvr_pkg::ACC_W;
   localparam int WW = qvr_pkg::WIDE_W;

   logic signed [31:0]    vec_ff [3];
   logic signed [31:0]    p_ff   [4];
   logic signed [31:0]    q_ff   [4];
   logic signed [31:0]    nq_ff  [4];
   logic signed [31:0]    mat_ff [9];
   logic signed [31:0]    mat_in [9];
   logic signed [1:0]     sign_ff;
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic signed [AW-1:0]  acc_ff, acc_in;
   logic signed [AW-1:0]  rowsum_ff [3];
   logic signed [TW-1:0]  term_ff [9];
   logic signed [31:0]    out_ff [3];
   logic signed [31:0]    out_in [3];

   logic                          dly_valid_ff;
   qvr_pkg::phase_type            dly_phase_ff;
   logic [qvr_pkg::STEP_W-1:0]    dly_step_ff;

   qvr_pkg::comp_op_type  iss_comp, dly_comp;
   qvr_pkg::sq_op_type    iss_sq;
   logic signed [31:0]    mul_a, mul_b;
   logic signed [TW-1:0]  term30, term29;
   logic signed [AW-1:0]  addend, base;
   logic signed [31:0]    q_new;
   logic signed [WW-1:0]  scaled [3];
   logic [WW-OUT_W:0]     top_bits [3];
   logic signed [OUT_W-1:0] narrow [3];
   logic signed [WW-1:0]  t [9];
   logic signed [WW-1:0]  one;

   // operand select and multiply
   always_comb begin
      iss_comp = qvr_pkg::compose_op(cmd.step);
      iss_sq   = qvr_pkg::square_op(cmd.step);
      case (cmd.phase)
         qvr_pkg::PH_COMPOSE: begin
            mul_a = q_ff[iss_comp.a_idx];
            mul_b = p_ff[iss_comp.b_idx];
         end
         qvr_pkg::PH_SQUARE: begin
            // nq mirrors q after the compose commit
            mul_a = q_ff[iss_sq.a_idx];
            mul_b = nq_ff[iss_sq.b_idx];
         end
         qvr_pkg::PH_ROTATE: begin
            mul_a = vec_ff[qvr_pkg::rot_col(cmd.step)];
            mul_b = mat_ff[cmd.step];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PW'(mul_a) * PW'(mul_b);
   end

   // accumulate stage, in the cycle after the multiply
   always_comb begin
      term30   = TW'(prod_ff >>> 30);
      term29   = TW'(prod_ff >>> 29);
      dly_comp = qvr_pkg::compose_op(dly_step_ff);
      if (dly_phase_ff == qvr_pkg::PH_COMPOSE) begin
         addend = dly_comp.neg ? -AW'(term30) : AW'(term30);
         base   = (dly_step_ff[1:0] == 2'd0) ? '0 : acc_ff;
      end else begin
         addend = AW'(term30);
         base   = (qvr_pkg::rot_col(dly_step_ff) == 2'd0) ? '0 : acc_ff;
      end
      acc_in = base + addend;
      q_new  = qvr_pkg::sat32(WW'(acc_in));
   end

   // matrix from the stored component products
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         t[i] = WW'(term_ff[i]);
      end
      one = WW'(qvr_pkg::ONE_Q30);
      mat_in[0] = qvr_pkg::sat32(one - t[qvr_pkg::SQ_YY] - t[qvr_pkg::SQ_ZZ]);
      mat_in[1] = qvr_pkg::sat32(t[qvr_pkg::SQ_XY] - t[qvr_pkg::SQ_ZW]);
      mat_in[2] = qvr_pkg::sat32(t[qvr_pkg::SQ_XZ] + t[qvr_pkg::SQ_YW]);
      mat_in[3] = qvr_pkg::sat32(t[qvr_pkg::SQ_XY] + t[qvr_pkg::SQ_ZW]);
      mat_in[4] = qvr_pkg::sat32(one - t[qvr_pkg::SQ_XX] - t[qvr_pkg::SQ_ZZ]);
      mat_in[5] = qvr_pkg::sat32(t[qvr_pkg::SQ_YZ] - t[qvr_pkg::SQ_XW]);
      mat_in[6] = qvr_pkg::sat32(t[qvr_pkg::SQ_XZ] - t[qvr_pkg::SQ_YW]);
      mat_in[7] = qvr_pkg::sat32(t[qvr_pkg::SQ_YZ] + t[qvr_pkg::SQ_XW]);
      mat_in[8] = qvr_pkg::sat32(one - t[qvr_pkg::SQ_XX] - t[qvr_pkg::SQ_YY]);
   end

   // sign scaling and output saturation per row
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         scaled[r]   = WW'(sign_ff) * WW'(rowsum_ff[r]);
         top_bits[r] = scaled[r][WW-1:OUT_W-1];
         if (&top_bits[r] || ~|top_bits[r]) begin
            narrow[r] = scaled[r][OUT_W-1:0];
         end else begin
            narrow[r] = {scaled[r][WW-1], {(OUT_W-1){~scaled[r][WW-1]}}};
         end
         out_in[r] = 32'(narrow[r]);
      end
   end

   // architectural state and pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff[0] <= '0;
         q_ff[1] <= '0;
         q_ff[2] <= '0;
         q_ff[3] <= qvr_pkg::ONE_Q30;
         for (int i = 0; i < 9; i++) begin
            mat_ff[i] <= (i % 4 == 0) ? qvr_pkg::ONE_Q30 : '0;
         end
         dly_valid_ff <= 1'b0;
      end else begin
         dly_valid_ff <= cmd.issue;
         if (dly_valid_ff && dly_phase_ff == qvr_pkg::PH_COMPOSE &&
             dly_step_ff == qvr_pkg::COMPOSE_LAST) begin
            q_ff[0] <= nq_ff[0];
            q_ff[1] <= nq_ff[1];
            q_ff[2] <= nq_ff[2];
            q_ff[3] <= q_new;
         end
         if (cmd.build) begin
            for (int i = 0; i < 9; i++) begin
               mat_ff[i] <= mat_in[i];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         vec_ff[0] <= req_vec_x;
         vec_ff[1] <= req_vec_y;
         vec_ff[2] <= req_vec_z;
         p_ff[0]   <= req_quat_x;
         p_ff[1]   <= req_quat_y;
         p_ff[2]   <= req_quat_z;
         p_ff[3]   <= req_quat_w;
         sign_ff   <= req_sign_mult;
      end
      prod_ff      <= prod_in;
      dly_phase_ff <= cmd.phase;
      dly_step_ff  <= cmd.step;
      if (dly_valid_ff) begin
         case (dly_phase_ff)
            qvr_pkg::PH_COMPOSE: begin
               acc_ff <= acc_in;
               if (dly_step_ff[1:0] == 2'd3) nq_ff[dly_step_ff[3:2]] <= q_new;
            end
            qvr_pkg::PH_SQUARE: begin
               term_ff[dly_step_ff] <= term29;
            end
            qvr_pkg::PH_ROTATE: begin
               acc_ff <= acc_in;
               if (qvr_pkg::rot_col(dly_step_ff) == 2'd2) begin
                  rowsum_ff[qvr_pkg::rot_row(dly_step_ff)] <= acc_in;
               end
            end
            default: ;
         endcase
      end
      if (cmd.out_load) begin
         for (int r = 0; r < 3; r++) begin
            out_ff[r] <= out_in[r];
         end
      end
   end

   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];

endmodule

FILE: rtl/core/quaternion_vector_rotator.sv
// top level of the quaternion vector rotator: sequencer plus datapath
// depends on qvr_pkg, qvr_ctrl, qvr_datapath and assert_macros.svh

// Rotates a Q16.16 vector by a stored orientation held as a Q2.30 quaternion and its
// cached 3x3 matrix; both reset to identity. An item with op = 0 goes from accept to
// result register as nine products through the single shared 32x32 multiplier
// plus pipeline drain and output load. An item with op = 1 first multiplies the stored
// quaternion by the item's quaternion (16 products), rebuilds the matrix (9 products and
// a build step) and then rotates. The next item can be taken the cycle after the result
// loads. The multiplier is the pacing unit: one product per cycle in the compose, square
// and rotate steps. req_stall is high while an item is in work; the result sits in its
// own register, so the next item is taken while it waits on rsp_stall.
// The result saturates to DATA_WIDTH bits (held within 16..32) and is sign extended.
`include "assert_macros.svh"

module quaternion_vector_rotator #(
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [1:0]  req_sign_mult,
   input  logic signed [31:0] req_quat_x,
   input  logic signed [31:0] req_quat_y,
   input  logic signed [31:0] req_quat_z,
   input  logic signed [31:0] req_quat_w,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z
);

   qvr_pkg::cmd_type cmd;

   qvr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   qvr_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_vec_x     (req_vec_x),
      .req_vec_y     (req_vec_y),
      .req_vec_z     (req_vec_z),
      .req_sign_mult (req_sign_mult),
      .req_quat_x    (req_quat_x),
      .req_quat_y    (req_quat_y),
      .req_quat_z    (req_quat_z),
      .req_quat_w    (req_quat_w),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z)
   );

   `QVR_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "no busy after item")
   `QVR_ASSERT_NOW(a_issue_only_busy, cmd.issue, req_stall, "multiply issued while idle")
   `QVR_ASSERT_NOW(a_no_overwrite, cmd.out_load, !rsp_valid || !rsp_stall, "result overwritten")
   `QVR_ASSERT_NOW(a_single_cmd, cmd.build || cmd.out_load, !cmd.issue, "build overlaps multiply")

endmodule
